/* hdl/nlat_pkg.sv */
package nlat_pkg;

	// Field widths of the item and result
	localparam int unsigned NODE_W      = 8;
	localparam int unsigned TICK_W      = 32;
	localparam int unsigned CMD_W       = 2;
	localparam int unsigned STATUS_W    = 3;
	localparam int unsigned SLOT_OUT_W  = 4;

	// Table defaults and limits
	localparam int unsigned SLOTS_DEF     = 16;
	localparam int unsigned MAX_RESULTS   = 16;
	localparam int unsigned CNT_W         = $clog2(MAX_RESULTS + 1);
	localparam logic [TICK_W-1:0] AGE_LIMIT_RST = 32'd30000;

	// Configuration register indexes
	localparam logic REG_AGE_LIMIT = 1'b0;

	// Command codes carried in tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_HEARTBEAT = 2'd0,
		CMD_CHECK     = 2'd1,
		CMD_DELETE    = 2'd2
	} cmd_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STS_REFRESHED    = 3'd0,
		STS_INSERTED     = 3'd1,
		STS_FULL         = 3'd2,
		STS_DELETED      = 3'd3,
		STS_NOT_FOUND    = 3'd4,
		STS_EXPIRED      = 3'd5,
		STS_NONE_EXPIRED = 3'd6
	} status_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} ctl_t;

	// Status from datapath to controller
	typedef struct packed {
		logic scan_done;
		logic out_free;
	} sts_t;

endpackage

/* hdl/nlat_ctrl.sv */
module nlat_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_tvalid,
	output logic            in_tready,
	output nlat_pkg::ctl_t  ctl,
	input  nlat_pkg::sts_t  sts
);

	nlat_pkg::state_t state_q;
	nlat_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nlat_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		in_tready  = 1'b0;
		ctl        = '0;
		case (state_q)
			nlat_pkg::S_IDLE: begin
				in_tready = 1'b1;
				if (in_tvalid) begin
					ctl.load = 1'b1;
					state_d  = nlat_pkg::S_SCAN;
				end
			end
			nlat_pkg::S_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = nlat_pkg::S_FINISH;
				end
			end
			nlat_pkg::S_FINISH: begin
				// wait for room in the output register
				if (sts.out_free) begin
					ctl.finish = 1'b1;
					state_d    = nlat_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = nlat_pkg::S_IDLE;
			end
		endcase
	end

endmodule

/* hdl/nlat_dp.sv */
module nlat_dp #(
	parameter int unsigned TABLE_SLOTS = nlat_pkg::SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  nlat_pkg::ctl_t                    ctl,
	output nlat_pkg::sts_t                    sts,
	input  logic [nlat_pkg::CMD_W-1:0]        in_cmd,
	input  logic [nlat_pkg::NODE_W-1:0]       in_node,
	input  logic [nlat_pkg::TICK_W-1:0]       in_now,
	input  logic [nlat_pkg::TICK_W-1:0]       age_limit,
	input  logic                              out_tready,
	output logic                              out_tvalid,
	output logic [nlat_pkg::STATUS_W-1:0]     out_status,
	output logic [nlat_pkg::NODE_W-1:0]       out_node,
	output logic [nlat_pkg::SLOT_OUT_W-1:0]   out_slot,
	output logic                              out_last
);

	localparam int unsigned AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);

	// Item registers
	logic [nlat_pkg::CMD_W-1:0]  cmd_q;
	logic [nlat_pkg::NODE_W-1:0] node_q;
	logic [nlat_pkg::TICK_W-1:0] now_q;

	// Table storage
	logic [nlat_pkg::NODE_W-1:0] mem_node  [TABLE_SLOTS];
	logic [nlat_pkg::TICK_W-1:0] mem_stamp [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0]      valid_q;

	// Scan pointer and evaluation stage
	logic [CW-1:0]               rd_cnt_q;
	logic                        ev_vld_s1;
	logic [AW-1:0]               ev_idx_s1;
	logic [nlat_pkg::NODE_W-1:0] node_s1;
	logic [nlat_pkg::TICK_W-1:0] stamp_s1;

	// Scan findings
	logic                        hit_q;
	logic [AW-1:0]               hit_idx_q;
	logic                        free_q;
	logic [AW-1:0]               free_idx_q;
	logic                        pend_q;
	logic [nlat_pkg::NODE_W-1:0] pend_node_q;
	logic [AW-1:0]               pend_idx_q;
	logic [nlat_pkg::CNT_W-1:0]  exp_cnt_q;

	// Output register
	logic                            out_vld_q;
	logic [nlat_pkg::STATUS_W-1:0]   out_status_q;
	logic [nlat_pkg::NODE_W-1:0]     out_node_q;
	logic [nlat_pkg::SLOT_OUT_W-1:0] out_slot_q;
	logic                            out_last_q;

	logic                        out_free;
	logic                        ev_valid;
	logic                        ev_match;
	logic [nlat_pkg::TICK_W-1:0] ev_age;
	logic                        expire_now;
	logic                        stall;
	logic                        ev_go;
	logic                        rd_more;
	logic                        rd_en;

	logic                            emit;
	logic [nlat_pkg::STATUS_W-1:0]   emit_status;
	logic [nlat_pkg::NODE_W-1:0]     emit_node;
	logic [nlat_pkg::SLOT_OUT_W-1:0] emit_slot;
	logic                            emit_last;

	logic                        wr_en;
	logic [AW-1:0]               wr_idx;
	logic                        set_vld;
	logic                        clr_fin;

	// Evaluation of the slot held in the registered read stage
	assign out_free   = !out_vld_q || out_tready;
	assign ev_valid   = valid_q[ev_idx_s1];
	assign ev_match   = ev_valid && (node_s1 == node_q);
	assign ev_age     = now_q - stamp_s1;
	assign expire_now = (cmd_q == nlat_pkg::CMD_CHECK) && ev_valid &&
	                    (ev_age > age_limit) &&
	                    (exp_cnt_q < nlat_pkg::CNT_W'(nlat_pkg::MAX_RESULTS));
	assign stall      = ev_vld_s1 && expire_now && pend_q && !out_free;
	assign ev_go      = ctl.scan && ev_vld_s1 && !stall;
	assign rd_more    = rd_cnt_q < CW'(TABLE_SLOTS);
	assign rd_en      = ctl.scan && !stall && rd_more;

	assign sts.scan_done = !rd_more && !ev_vld_s1;
	assign sts.out_free  = out_free;

	// Result selection and end-of-item table updates
	always_comb begin
		emit        = 1'b0;
		emit_status = nlat_pkg::STS_NONE_EXPIRED;
		emit_node   = '0;
		emit_slot   = '0;
		emit_last   = 1'b0;
		wr_en       = 1'b0;
		wr_idx      = hit_idx_q;
		set_vld     = 1'b0;
		clr_fin     = 1'b0;
		if (ev_go && expire_now && pend_q) begin
			// a newer expiry pushes out the held one
			emit        = 1'b1;
			emit_status = nlat_pkg::STS_EXPIRED;
			emit_node   = pend_node_q;
			emit_slot   = nlat_pkg::SLOT_OUT_W'(pend_idx_q);
		end else if (ctl.finish) begin
			emit_last = 1'b1;
			emit_node = node_q;
			case (cmd_q)
				nlat_pkg::CMD_HEARTBEAT: begin
					emit = 1'b1;
					if (hit_q) begin
						emit_status = nlat_pkg::STS_REFRESHED;
						emit_slot   = nlat_pkg::SLOT_OUT_W'(hit_idx_q);
						wr_en       = 1'b1;
					end else if (free_q) begin
						emit_status = nlat_pkg::STS_INSERTED;
						emit_slot   = nlat_pkg::SLOT_OUT_W'(free_idx_q);
						wr_en       = 1'b1;
						wr_idx      = free_idx_q;
						set_vld     = 1'b1;
					end else begin
						emit_status = nlat_pkg::STS_FULL;
					end
				end
				nlat_pkg::CMD_DELETE: begin
					emit = 1'b1;
					if (hit_q) begin
						emit_status = nlat_pkg::STS_DELETED;
						emit_slot   = nlat_pkg::SLOT_OUT_W'(hit_idx_q);
						clr_fin     = 1'b1;
					end else begin
						emit_status = nlat_pkg::STS_NOT_FOUND;
					end
				end
				nlat_pkg::CMD_CHECK: begin
					emit = 1'b1;
					if (pend_q) begin
						emit_status = nlat_pkg::STS_EXPIRED;
						emit_node   = pend_node_q;
						emit_slot   = nlat_pkg::SLOT_OUT_W'(pend_idx_q);
					end else begin
						emit_status = nlat_pkg::STS_NONE_EXPIRED;
						emit_node   = '0;
					end
				end
				default: begin
					// unused command: no result
					emit = 1'b0;
				end
			endcase
		end
	end

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_node[wr_idx]  <= node_q;
			mem_stamp[wr_idx] <= now_q;
		end
		if (rd_en) begin
			node_s1  <= mem_node[rd_cnt_q[AW-1:0]];
			stamp_s1 <= mem_stamp[rd_cnt_q[AW-1:0]];
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ev_go && expire_now) begin
				valid_q[ev_idx_s1] <= 1'b0;
			end
			if (set_vld) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (clr_fin) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	// Item payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= in_cmd;
			node_q <= in_node;
			now_q  <= in_now;
		end
	end

	// Scan control and findings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q  <= '0;
			ev_vld_s1 <= 1'b0;
			ev_idx_s1 <= '0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			pend_q    <= 1'b0;
			exp_cnt_q <= '0;
		end else if (ctl.load) begin
			rd_cnt_q  <= '0;
			ev_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			pend_q    <= 1'b0;
			exp_cnt_q <= '0;
		end else if (ctl.scan && !stall) begin
			ev_vld_s1 <= rd_more;
			if (rd_more) begin
				ev_idx_s1 <= rd_cnt_q[AW-1:0];
				rd_cnt_q  <= rd_cnt_q + 1'b1;
			end
			if (ev_vld_s1) begin
				if (ev_match && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!ev_valid && !free_q) begin
					free_q <= 1'b1;
				end
				if (expire_now) begin
					pend_q    <= 1'b1;
					exp_cnt_q <= exp_cnt_q + 1'b1;
				end
			end
		end
	end

	// Finding payloads, qualified by the flags above
	always_ff @(posedge clk) begin
		if (ev_go) begin
			if (ev_match && !hit_q) begin
				hit_idx_q <= ev_idx_s1;
			end
			if (!ev_valid && !free_q) begin
				free_idx_q <= ev_idx_s1;
			end
			if (expire_now) begin
				pend_node_q <= node_s1;
				pend_idx_q  <= ev_idx_s1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (out_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_status_q <= emit_status;
			out_node_q   <= emit_node;
			out_slot_q   <= emit_slot;
			out_last_q   <= emit_last;
		end
	end

	assign out_tvalid = out_vld_q;
	assign out_status = out_status_q;
	assign out_node   = out_node_q;
	assign out_slot   = out_slot_q;
	assign out_last   = out_last_q;

endmodule

/* hdl/neighbor_liveness_aging_table.sv */
// A result leaves after the slot scan that follows acceptance of its item; a
// check gives one result per expired slot (at most MAX_RESULTS) or one
// none-expired result, all but the last during the scan. Items are taken only
// in idle; the scan reads one table entry per cycle unless the output stalls.
// Reset: all slots free, age limit 30000, no result pending.
module neighbor_liveness_aging_table #(
	parameter int unsigned TABLE_SLOTS = nlat_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// item in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [7:0] node_id, [39:8] now_tick
	input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
	// result out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [2:0] status, [10:3] reported_node,
	                                   // [14:11] slot_index, [15] zero
	output logic        m_axis_tlast,  // last_result
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	nlat_pkg::ctl_t ctl;
	nlat_pkg::sts_t sts;

	logic [nlat_pkg::TICK_W-1:0]     age_limit_q;
	logic [nlat_pkg::STATUS_W-1:0]   res_status;
	logic [nlat_pkg::NODE_W-1:0]     res_node;
	logic [nlat_pkg::SLOT_OUT_W-1:0] res_slot;

	// Configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q <= nlat_pkg::AGE_LIMIT_RST;
		end else if (psel && penable && pwrite && pready &&
		             (paddr[2] == nlat_pkg::REG_AGE_LIMIT)) begin
			age_limit_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == nlat_pkg::REG_AGE_LIMIT) ? age_limit_q : '0;

	nlat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tvalid (s_axis_tvalid),
		.in_tready (s_axis_tready),
		.ctl       (ctl),
		.sts       (sts)
	);

	nlat_dp #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.in_cmd     (s_axis_tuser),
		.in_node    (s_axis_tdata[7:0]),
		.in_now     (s_axis_tdata[39:8]),
		.age_limit  (age_limit_q),
		.out_tready (m_axis_tready),
		.out_tvalid (m_axis_tvalid),
		.out_status (res_status),
		.out_node   (res_node),
		.out_slot   (res_slot),
		.out_last   (m_axis_tlast)
	);

	// Pack result fields
	assign m_axis_tdata = {1'b0, res_slot, res_node, res_status};

endmodule
